/* rtl/ptd_pkg.sv */
// ----------------------------------------------------------------------------
// ptd_pkg
// Widths, codes and helpers shared by the point-to-triangle distance pipeline.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;     // P - V0, V1 - V0, V2 - V0
    localparam int PROD_W    = 2 * DIFF_W;      // one coordinate product
    localparam int DOT_W     = PROD_W + 2;      // sum of three products
    localparam int HALF_W    = DOT_W / 2;       // split for the wide multiplies
    localparam int PP_W      = 2 * (HALF_W + 1);
    localparam int WIDE_W    = 2 * DOT_W + 4;   // det, s, t numerators
    localparam int SM_W      = DOT_W + 3;       // small sums of dot products
    localparam int DIV_W     = WIDE_W - 2;      // unsigned divider operands
    localparam int T_FRAC    = 24;
    localparam int T_W       = T_FRAC + 1;      // barycentric parameter, [0, 1]
    localparam int TP_W      = T_W + DIFF_W + 1;
    localparam int RES_W     = 52;              // residual before rounding
    localparam int Q_W       = RES_W - T_FRAC;  // rounded residual magnitude
    localparam int SQ_W      = 2 * Q_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_TOP  = SUM_W - 2;       // top power of four of the root
    localparam int ROOT_STEPS = ROOT_TOP / 2 + 1;
    localparam int DIST_W    = COORD_W + 1;

    localparam logic [T_W-1:0]   T_ONE  = T_W'(1) << T_FRAC;
    localparam logic [RES_W-1:0] T_HALF = RES_W'(1) << (T_FRAC - 1);

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DOT_W-1:0]  t_dot;
    typedef logic signed [PP_W-1:0]   t_pp;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [SM_W-1:0]   t_sm;

    // Source of each barycentric parameter after classification
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_ONE,
        SEL_QA,
        SEL_ONE_MINUS_QA,
        SEL_QB
    } t_sel;

    localparam logic [2:0] REG_INTERIOR = 3'd0;
    localparam logic [2:0] REG_EDGE_12  = 3'd1;
    localparam logic [2:0] REG_CORNER_2 = 3'd2;
    localparam logic [2:0] REG_EDGE_02  = 3'd3;
    localparam logic [2:0] REG_CORNER_0 = 3'd4;
    localparam logic [2:0] REG_EDGE_01  = 3'd5;
    localparam logic [2:0] REG_CORNER_1 = 3'd6;

    typedef struct packed {
        t_diff [2:0] dv;
        t_diff [2:0] e0;
        t_diff [2:0] e1;
    } t_geo;

    typedef struct packed {
        t_dot a00;
        t_dot a11;
        t_dot b0;
        t_dot b1;
        t_sm  den;
        t_sm  tmp1_two;
        t_sm  diff_two;
        t_sm  tmp1_six;
        t_sm  diff_six;
    } t_small;

    typedef struct packed {
        logic [2:0] region;
        t_sel       sel0;
        t_sel       sel1;
        logic       bad;
        t_geo       geo;
    } t_side;

    function automatic t_diff sext_c(input logic [COORD_W-1:0] x);
        return t_diff'({x[COORD_W-1], x});
    endfunction

    // signed upper half and unsigned lower half, both as signed operands
    function automatic logic signed [HALF_W:0] hi_part(input logic [DOT_W-1:0] x);
        return {x[DOT_W-1], x[DOT_W-1:HALF_W]};
    endfunction

    function automatic logic signed [HALF_W:0] lo_part(input logic [DOT_W-1:0] x);
        return {1'b0, x[HALF_W-1:0]};
    endfunction

endpackage

/* rtl/ptd_div.sv */
// ----------------------------------------------------------------------------
// ptd_div
// Pipelined restoring divider, one quotient bit per stage. Returns
// floor(num * 2^T_FRAC / den), or exactly one when num >= den.
// ----------------------------------------------------------------------------
module ptd_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ptd_pkg::DIV_W-1:0]   i_num,
    input  logic [ptd_pkg::DIV_W-1:0]   i_den,
    output logic [ptd_pkg::T_W-1:0]     o_quot
);
    import ptd_pkg::*;

    logic [DIV_W-1:0]  r_rem [T_FRAC];
    logic [DIV_W-1:0]  r_den [T_FRAC];
    logic [T_FRAC-1:0] r_q   [T_FRAC];
    logic              r_sat [T_FRAC];

    for (genvar k = 0; k < T_FRAC; k++) begin : g_step
        logic [DIV_W-1:0]  w_rem_in;
        logic [DIV_W-1:0]  w_den_in;
        logic [T_FRAC-1:0] w_q_in;
        logic              w_sat_in;
        logic [DIV_W:0]    w_shift;
        logic              w_fit;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_q_in   = '0;
            assign w_sat_in = (i_num >= i_den);
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_q_in   = r_q[k-1];
            assign w_sat_in = r_sat[k-1];
        end

        assign w_shift = {w_rem_in, 1'b0};
        assign w_fit   = (w_shift >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_fit ? DIV_W'(w_shift - {1'b0, w_den_in}) : w_shift[DIV_W-1:0];
                r_den[k] <= w_den_in;
                r_q[k]   <= {w_q_in[T_FRAC-2:0], w_fit};
                r_sat[k] <= w_sat_in;
            end
        end
    end

    assign o_quot = r_sat[T_FRAC-1] ? T_ONE : {1'b0, r_q[T_FRAC-1]};

endmodule

/* rtl/point_triangle_distance_unit.sv */
// ----------------------------------------------------------------------------
// point_triangle_distance_unit
// Distance from a point to a 3D triangle with region code, fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one point/triangle beat is taken every cycle while o_stall
// is low. Most of the pipe is the 24-stage quotient dividers (one bit per
// stage) and the 29-stage square root (one root bit per stage); the rest is
// dot products, split 52x52 multiplies and the region sort. A two-entry
// output buffer (output register plus skid) decouples o_stall from i_stall,
// so the whole pipe holds only while both entries are full. There is no
// state between beats. A degenerate triangle (zero or negative determinant
// in the interior case) returns the distance to V0 with o_degenerate set.
// ----------------------------------------------------------------------------
module point_triangle_distance_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_point_y,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_point_z,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_v0_x,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_v0_y,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_v0_z,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_v1_x,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_v1_y,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_v1_z,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_v2_x,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_v2_y,
    input  logic signed [ptd_pkg::COORD_W-1:0]   i_v2_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [ptd_pkg::DIST_W-1:0]           o_distance,
    output logic [2:0]                           o_region,
    output logic                                 o_degenerate
);
    import ptd_pkg::*;

    logic w_adv;
    logic w_take;

    // ---------------- stage 1: differences ----------------
    logic [COORD_W-1:0] w_p [3];
    logic [COORD_W-1:0] w_v0 [3];
    logic [COORD_W-1:0] w_v1 [3];
    logic [COORD_W-1:0] w_v2 [3];
    t_geo               w_geo_in;
    logic               r1_v;
    t_geo               r1_geo;

    assign w_p[0]  = i_point_x;
    assign w_p[1]  = i_point_y;
    assign w_p[2]  = i_point_z;
    assign w_v0[0] = i_v0_x;
    assign w_v0[1] = i_v0_y;
    assign w_v0[2] = i_v0_z;
    assign w_v1[0] = i_v1_x;
    assign w_v1[1] = i_v1_y;
    assign w_v1[2] = i_v1_z;
    assign w_v2[0] = i_v2_x;
    assign w_v2[1] = i_v2_y;
    assign w_v2[2] = i_v2_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_geo_in.dv[k] = sext_c(w_p[k])  - sext_c(w_v0[k]);
            w_geo_in.e0[k] = sext_c(w_v1[k]) - sext_c(w_v0[k]);
            w_geo_in.e1[k] = sext_c(w_v2[k]) - sext_c(w_v0[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_geo <= w_geo_in;
        end
    end

    // ---------------- stage 2: coordinate products ----------------
    logic  r2_v;
    t_geo  r2_geo;
    t_prod r2_pde0 [3];
    t_prod r2_pde1 [3];
    t_prod r2_pe00 [3];
    t_prod r2_pe01 [3];
    t_prod r2_pe11 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_geo <= r1_geo;
            for (int k = 0; k < 3; k++) begin
                r2_pde0[k] <= $signed(r1_geo.dv[k]) * $signed(r1_geo.e0[k]);
                r2_pde1[k] <= $signed(r1_geo.dv[k]) * $signed(r1_geo.e1[k]);
                r2_pe00[k] <= $signed(r1_geo.e0[k]) * $signed(r1_geo.e0[k]);
                r2_pe01[k] <= $signed(r1_geo.e0[k]) * $signed(r1_geo.e1[k]);
                r2_pe11[k] <= $signed(r1_geo.e1[k]) * $signed(r1_geo.e1[k]);
            end
        end
    end

    // ---------------- stage 3: dot products ----------------
    logic r3_v;
    t_geo r3_geo;
    t_dot r3_a00, r3_a01, r3_a11, r3_b0, r3_b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_geo <= r2_geo;
            r3_a00 <= DOT_W'(r2_pe00[0]) + DOT_W'(r2_pe00[1]) + DOT_W'(r2_pe00[2]);
            r3_a01 <= DOT_W'(r2_pe01[0]) + DOT_W'(r2_pe01[1]) + DOT_W'(r2_pe01[2]);
            r3_a11 <= DOT_W'(r2_pe11[0]) + DOT_W'(r2_pe11[1]) + DOT_W'(r2_pe11[2]);
            r3_b0  <= -(DOT_W'(r2_pde0[0]) + DOT_W'(r2_pde0[1]) + DOT_W'(r2_pde0[2]));
            r3_b1  <= -(DOT_W'(r2_pde1[0]) + DOT_W'(r2_pde1[1]) + DOT_W'(r2_pde1[2]));
        end
    end

    // ---------------- stage 4: partial products, small sums ----------------
    // pairs: a00*a11, a01*a01, a01*b1, a11*b0, a01*b0, a00*b1
    t_dot   w_mx [6];
    t_dot   w_my [6];
    t_small w_small;
    logic   r4_v;
    t_geo   r4_geo;
    t_small r4_small;
    t_pp    r4_pp [6][4];

    assign w_mx[0] = r3_a00;
    assign w_my[0] = r3_a11;
    assign w_mx[1] = r3_a01;
    assign w_my[1] = r3_a01;
    assign w_mx[2] = r3_a01;
    assign w_my[2] = r3_b1;
    assign w_mx[3] = r3_a11;
    assign w_my[3] = r3_b0;
    assign w_mx[4] = r3_a01;
    assign w_my[4] = r3_b0;
    assign w_mx[5] = r3_a00;
    assign w_my[5] = r3_b1;

    always_comb begin
        w_small.a00      = r3_a00;
        w_small.a11      = r3_a11;
        w_small.b0       = r3_b0;
        w_small.b1       = r3_b1;
        w_small.den      = SM_W'(r3_a00) - (SM_W'(r3_a01) <<< 1) + SM_W'(r3_a11);
        w_small.tmp1_two = SM_W'(r3_a11) + SM_W'(r3_b1);
        w_small.diff_two = SM_W'(r3_a11) + SM_W'(r3_b1) - SM_W'(r3_a01) - SM_W'(r3_b0);
        w_small.tmp1_six = SM_W'(r3_a00) + SM_W'(r3_b0);
        w_small.diff_six = SM_W'(r3_a00) + SM_W'(r3_b0) - SM_W'(r3_a01) - SM_W'(r3_b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_geo   <= r3_geo;
            r4_small <= w_small;
            for (int j = 0; j < 6; j++) begin
                r4_pp[j][0] <= hi_part(w_mx[j]) * hi_part(w_my[j]);
                r4_pp[j][1] <= hi_part(w_mx[j]) * lo_part(w_my[j]);
                r4_pp[j][2] <= lo_part(w_mx[j]) * hi_part(w_my[j]);
                r4_pp[j][3] <= lo_part(w_mx[j]) * lo_part(w_my[j]);
            end
        end
    end

    // ---------------- stage 5: full products ----------------
    logic   r5_v;
    t_geo   r5_geo;
    t_small r5_small;
    t_wide  r5_prod [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_geo   <= r4_geo;
            r5_small <= r4_small;
            for (int j = 0; j < 6; j++) begin
                r5_prod[j] <= (WIDE_W'(r4_pp[j][0]) <<< (2 * HALF_W))
                            + ((WIDE_W'(r4_pp[j][1]) + WIDE_W'(r4_pp[j][2])) <<< HALF_W)
                            + WIDE_W'(r4_pp[j][3]);
            end
        end
    end

    // ---------------- stage 6: det, s and t numerators ----------------
    logic   r6_v;
    t_geo   r6_geo;
    t_small r6_small;
    t_wide  r6_det, r6_t0, r6_t1, r6_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_adv) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_geo   <= r5_geo;
            r6_small <= r5_small;
            r6_det   <= r5_prod[0] - r5_prod[1];
            r6_t0    <= r5_prod[2] - r5_prod[3];
            r6_t1    <= r5_prod[4] - r5_prod[5];
            r6_sum   <= r5_prod[2] - r5_prod[3] + r5_prod[4] - r5_prod[5];
        end
    end

    // ---------------- stage 7: region sort, divider operands ----------------
    t_side            w_side;
    logic [DIV_W-1:0] w_na, w_da, w_nb, w_db;
    logic             r7_v;
    t_side            r7_side;
    logic [DIV_W-1:0] r7_na, r7_da, r7_nb, r7_db;

    always_comb begin
        logic in_tri;
        logic neg_t0;
        logic neg_t1;
        logic b0_neg;
        logic b1_neg;
        logic two;
        t_sm  diff;
        t_sm  tmp1;
        t_sm  nb0;
        t_sm  nb1;

        in_tri = ($signed(r6_sum) <= $signed(r6_det));
        neg_t0 = r6_t0[WIDE_W-1];
        neg_t1 = r6_t1[WIDE_W-1];
        b0_neg = r6_small.b0[DOT_W-1];
        b1_neg = r6_small.b1[DOT_W-1];
        two    = neg_t0;
        diff   = two ? r6_small.diff_two : r6_small.diff_six;
        tmp1   = two ? r6_small.tmp1_two : r6_small.tmp1_six;
        nb0    = -SM_W'(r6_small.b0);
        nb1    = -SM_W'(r6_small.b1);

        w_side.geo    = r6_geo;
        w_side.region = REG_INTERIOR;
        w_side.sel0   = SEL_ZERO;
        w_side.sel1   = SEL_ZERO;
        w_side.bad    = 1'b0;
        w_na = '0;
        w_da = '0;
        w_nb = '0;
        w_db = '0;

        if (in_tri) begin
            if (neg_t0) begin
                if (neg_t1 && b0_neg) begin
                    w_side.region = REG_CORNER_0;
                    w_side.sel0   = SEL_QA;
                    w_na = DIV_W'(nb0);
                    w_da = DIV_W'(r6_small.a00);
                end else begin
                    w_side.region = neg_t1 ? REG_CORNER_0 : REG_EDGE_02;
                    w_side.sel1   = b1_neg ? SEL_QA : SEL_ZERO;
                    w_na = DIV_W'(nb1);
                    w_da = DIV_W'(r6_small.a11);
                end
            end else if (neg_t1) begin
                w_side.region = REG_EDGE_01;
                w_side.sel0   = b0_neg ? SEL_QA : SEL_ZERO;
                w_na = DIV_W'(nb0);
                w_da = DIV_W'(r6_small.a00);
            end else begin
                w_side.region = REG_INTERIOR;
                w_side.sel0   = SEL_QA;
                w_side.sel1   = SEL_QB;
                w_side.bad    = r6_det[WIDE_W-1] || (r6_det == '0);
                w_na = DIV_W'(r6_t0);
                w_da = DIV_W'(r6_det);
                w_nb = DIV_W'(r6_t1);
                w_db = DIV_W'(r6_det);
            end
        end else if (neg_t0 || neg_t1) begin
            w_side.region = two ? REG_CORNER_2 : REG_CORNER_1;
            if (!diff[SM_W-1] && (diff != '0)) begin
                // far parameter weights the vertex beside the corner
                w_side.sel0 = two ? SEL_QA : SEL_ONE_MINUS_QA;
                w_side.sel1 = two ? SEL_ONE_MINUS_QA : SEL_QA;
                w_na = DIV_W'(diff);
                w_da = DIV_W'(r6_small.den);
            end else if (tmp1[SM_W-1] || (tmp1 == '0)) begin
                w_side.sel0 = two ? SEL_ZERO : SEL_ONE;
                w_side.sel1 = two ? SEL_ONE : SEL_ZERO;
            end else if (two) begin
                w_side.sel1 = b1_neg ? SEL_QA : SEL_ZERO;
                w_na = DIV_W'(nb1);
                w_da = DIV_W'(r6_small.a11);
            end else begin
                w_side.sel0 = b0_neg ? SEL_QA : SEL_ZERO;
                w_na = DIV_W'(nb0);
                w_da = DIV_W'(r6_small.a00);
            end
        end else begin
            w_side.region = REG_EDGE_12;
            if (r6_small.diff_two[SM_W-1] || (r6_small.diff_two == '0)) begin
                w_side.sel1 = SEL_ONE;
            end else begin
                w_side.sel0 = SEL_QA;
                w_side.sel1 = SEL_ONE_MINUS_QA;
                w_na = DIV_W'(r6_small.diff_two);
                w_da = DIV_W'(r6_small.den);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_adv) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_side <= w_side;
            r7_na   <= w_na;
            r7_da   <= w_da;
            r7_nb   <= w_nb;
            r7_db   <= w_db;
        end
    end

    // ---------------- dividers, sideband travels alongside ----------------
    logic [T_W-1:0] w_qa, w_qb;
    logic           rq_v    [T_FRAC];
    t_side          rq_side [T_FRAC];

    ptd_div u_div_a (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r7_na),
        .i_den  (r7_da),
        .o_quot (w_qa)
    );

    ptd_div u_div_b (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r7_nb),
        .i_den  (r7_db),
        .o_quot (w_qb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < T_FRAC; k++) begin
                rq_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            rq_v[0] <= r7_v;
            for (int k = 1; k < T_FRAC; k++) begin
                rq_v[k] <= rq_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rq_side[0] <= r7_side;
            for (int k = 1; k < T_FRAC; k++) begin
                rq_side[k] <= rq_side[k-1];
            end
        end
    end

    // ---------------- stage 8: parameter select ----------------
    function automatic logic [T_W-1:0] pick(input t_sel sel, input logic [T_W-1:0] qa,
                                            input logic [T_W-1:0] qb);
        logic [T_W-1:0] val;
        unique case (sel)
            SEL_ZERO:         val = '0;
            SEL_ONE:          val = T_ONE;
            SEL_QA:           val = qa;
            SEL_ONE_MINUS_QA: val = T_ONE - qa;
            SEL_QB:           val = qb;
            default:          val = '0;
        endcase
        return val;
    endfunction

    t_side          w_sq_side;
    logic           r8_v;
    t_geo           r8_geo;
    logic [2:0]     r8_region;
    logic           r8_bad;
    logic [T_W-1:0] r8_t0, r8_t1;

    assign w_sq_side = rq_side[T_FRAC-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (w_adv) begin
            r8_v <= rq_v[T_FRAC-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_geo    <= w_sq_side.geo;
            r8_region <= w_sq_side.region;
            r8_bad    <= w_sq_side.bad;
            r8_t0     <= w_sq_side.bad ? '0 : pick(w_sq_side.sel0, w_qa, w_qb);
            r8_t1     <= w_sq_side.bad ? '0 : pick(w_sq_side.sel1, w_qa, w_qb);
        end
    end

    // ---------------- stage 9: t * edge products ----------------
    logic                    r9_v;
    t_diff                   r9_dv [3];
    logic [2:0]              r9_region;
    logic                    r9_bad;
    logic signed [TP_W-1:0]  r9_p0 [3];
    logic signed [TP_W-1:0]  r9_p1 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (w_adv) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_region <= r8_region;
            r9_bad    <= r8_bad;
            for (int k = 0; k < 3; k++) begin
                r9_dv[k] <= r8_geo.dv[k];
                r9_p0[k] <= $signed({1'b0, r8_t0}) * $signed(r8_geo.e0[k]);
                r9_p1[k] <= $signed({1'b0, r8_t1}) * $signed(r8_geo.e1[k]);
            end
        end
    end

    // ---------------- stage 10: residual ----------------
    logic                    r10_v;
    logic [2:0]              r10_region;
    logic                    r10_bad;
    logic signed [RES_W-1:0] r10_r [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (w_adv) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_region <= r9_region;
            r10_bad    <= r9_bad;
            for (int k = 0; k < 3; k++) begin
                r10_r[k] <= (RES_W'(r9_dv[k]) <<< T_FRAC) - RES_W'(r9_p0[k])
                          - RES_W'(r9_p1[k]);
            end
        end
    end

    // ---------------- stage 11: magnitude, round half away ----------------
    logic [RES_W-1:0] w_mag [3];
    logic [RES_W-1:0] w_rnd [3];
    logic             r11_v;
    logic [2:0]       r11_region;
    logic             r11_bad;
    logic [Q_W-1:0]   r11_q [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r10_r[k][RES_W-1] ? RES_W'(-r10_r[k]) : RES_W'(r10_r[k]);
            w_rnd[k] = w_mag[k] + T_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (w_adv) begin
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r11_region <= r10_region;
            r11_bad    <= r10_bad;
            for (int k = 0; k < 3; k++) begin
                r11_q[k] <= w_rnd[k][T_FRAC +: Q_W];
            end
        end
    end

    // ---------------- stage 12: squares ----------------
    logic            r12_v;
    logic [2:0]      r12_region;
    logic            r12_bad;
    logic [SQ_W-1:0] r12_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else if (w_adv) begin
            r12_v <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r12_region <= r11_region;
            r12_bad    <= r11_bad;
            for (int k = 0; k < 3; k++) begin
                r12_sq[k] <= r11_q[k] * r11_q[k];
            end
        end
    end

    // ---------------- stage 13: sum of squares ----------------
    logic             r13_v;
    logic [2:0]       r13_region;
    logic             r13_bad;
    logic [SUM_W-1:0] r13_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_v <= 1'b0;
        end else if (w_adv) begin
            r13_v <= r12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r13_region <= r12_region;
            r13_bad    <= r12_bad;
            r13_sum    <= SUM_W'(r12_sq[0]) + SUM_W'(r12_sq[1]) + SUM_W'(r12_sq[2]);
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic             rs_v      [ROOT_STEPS];
    logic [2:0]       rs_region [ROOT_STEPS];
    logic             rs_bad    [ROOT_STEPS];
    logic [SUM_W-1:0] rs_n      [ROOT_STEPS];
    logic [SUM_W-1:0] rs_res    [ROOT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_STEPS; k++) begin
                rs_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            rs_v[0] <= r13_v;
            for (int k = 1; k < ROOT_STEPS; k++) begin
                rs_v[k] <= rs_v[k-1];
            end
        end
    end

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (ROOT_TOP - 2 * k);
        logic [SUM_W-1:0] w_n_in;
        logic [SUM_W-1:0] w_res_in;
        logic [2:0]       w_region_in;
        logic             w_bad_in;
        logic [SUM_W:0]   w_trial;
        logic             w_fit;

        if (k == 0) begin : g_first
            assign w_n_in      = r13_sum;
            assign w_res_in    = '0;
            assign w_region_in = r13_region;
            assign w_bad_in    = r13_bad;
        end else begin : g_next
            assign w_n_in      = rs_n[k-1];
            assign w_res_in    = rs_res[k-1];
            assign w_region_in = rs_region[k-1];
            assign w_bad_in    = rs_bad[k-1];
        end

        assign w_trial = {1'b0, w_res_in} + {1'b0, BIT};
        assign w_fit   = ({1'b0, w_n_in} >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                rs_n[k]      <= w_fit ? SUM_W'({1'b0, w_n_in} - w_trial) : w_n_in;
                rs_res[k]    <= w_fit ? (w_res_in >> 1) + BIT : (w_res_in >> 1);
                rs_region[k] <= w_region_in;
                rs_bad[k]    <= w_bad_in;
            end
        end
    end

    // ---------------- round, saturate, output buffer ----------------
    logic [SUM_W-1:0]  w_root;
    logic [DIST_W-1:0] w_tail_dist;
    logic              w_tail_v;
    logic              r_out_v;
    logic              r_skid_v;
    logic [DIST_W-1:0] r_out_dist, r_skid_dist;
    logic [2:0]        r_out_region, r_skid_region;
    logic              r_out_bad, r_skid_bad;

    assign w_root = rs_res[ROOT_STEPS-1]
                  + SUM_W'(rs_n[ROOT_STEPS-1] > rs_res[ROOT_STEPS-1]);
    assign w_tail_dist = (|w_root[SUM_W-1:DIST_W]) ? {DIST_W{1'b1}} : w_root[DIST_W-1:0];
    assign w_tail_v    = rs_v[ROOT_STEPS-1];

    // pipe moves whenever the skid entry is free
    assign w_adv  = !r_skid_v;
    assign w_take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_tail_v) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out_dist   <= r_skid_dist;
                r_out_region <= r_skid_region;
                r_out_bad    <= r_skid_bad;
            end
        end else if (w_tail_v) begin
            if (!r_out_v || w_take) begin
                r_out_dist   <= w_tail_dist;
                r_out_region <= rs_region[ROOT_STEPS-1];
                r_out_bad    <= rs_bad[ROOT_STEPS-1];
            end else begin
                r_skid_dist   <= w_tail_dist;
                r_skid_region <= rs_region[ROOT_STEPS-1];
                r_skid_bad    <= rs_bad[ROOT_STEPS-1];
            end
        end
    end

    assign o_stall      = r_skid_v;
    assign o_valid      = r_out_v;
    assign o_distance   = r_out_dist;
    assign o_region     = r_out_region;
    assign o_degenerate = r_out_bad;

endmodule
